// ----- hw/rtl/tdk_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_pkg
// Shared types and constants of the two-dimensional k-means clusterer.
// ----------------------------------------------------------------------------
package tdk_pkg;

  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 10;
  localparam int LABEL_W  = 4;
  localparam int ITER_W   = 8;
  localparam int STATUS_W = 3;
  localparam int KCFG_W   = 5;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_BAD_K, ST_BAD_ITER, ST_RANGE, ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last;
    logic [INDEX_W-1:0]        index;
  } in_t;

  typedef struct packed {
    logic                kind;
    logic [LABEL_W-1:0]  label;
    logic [ITER_W-1:0]   iterations_done;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic [KCFG_W-1:0] cluster_count;
    logic [ITER_W-1:0] max_iterations;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT,
    S_SD_RD0, S_SD_WR0, S_SD_RD, S_SD_DST, S_SD_WT, S_SD_FRD, S_SD_FWR,
    S_AS_RD, S_AS_CRD, S_AS_DST, S_AS_WT, S_AS_WR,
    S_CL, S_AC_RD, S_AC_CRD, S_AC_WR,
    S_DV_RD, S_DV_X, S_DV_XW, S_DV_Y, S_DV_YW,
    S_DONE
  } state_t;

endpackage : tdk_pkg
`default_nettype wire

// ----- hw/rtl/tdk_dist.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_dist
// Three-stage squared Euclidean distance between a point and a centroid.
// ----------------------------------------------------------------------------
module tdk_dist
  import tdk_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [COORD_W-1:0]   px,
  input  wire logic signed [COORD_W-1:0]   py,
  input  wire logic signed [COORD_W-1:0]   cx,
  input  wire logic signed [COORD_W-1:0]   cy,
  output logic                             valid,
  output logic [2*COORD_W+1:0]             dsq
);

  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] sx, sy;
  logic                        v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= start;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= (COORD_W+1)'(px) - (COORD_W+1)'(cx);
    dy  <= (COORD_W+1)'(py) - (COORD_W+1)'(cy);
    sx  <= dx * dx;
    sy  <= dy * dy;
    dsq <= $unsigned(sx) + $unsigned(sy);
  end

endmodule : tdk_dist
`default_nettype wire

// ----- hw/rtl/tdk_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tdk_div
  import tdk_pkg::*;
#(
  parameter int ACCW = 28,
  parameter int DVW  = 11
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [ACCW-1:0] dividend,
  input  wire logic [DVW-1:0]         divisor,
  output logic                        done,
  output logic signed [ACCW-1:0]      quotient
);

  localparam int CNT_W = $clog2(ACCW + 1);

  logic             busy;
  logic             neg;
  logic [ACCW-1:0]  mag;
  logic [DVW-1:0]   rem;
  logic [DVW-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVW:0]     shifted;
  logic             fits;

  assign shifted  = {rem, mag[ACCW-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && cnt == CNT_W'(1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[ACCW-1];
      mag <= dividend[ACCW-1] ? $unsigned(-dividend) : $unsigned(dividend);
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(ACCW);
    end else if (busy) begin
      rem <= fits ? DVW'(shifted - {1'b0, dvs}) : DVW'(shifted);
      mag <= {mag[ACCW-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule : tdk_div
`default_nettype wire

// ----- hw/rtl/tdk_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_engine
// Point, label, distance and centroid memories with the sequencer that loads
// points, answers label reads and runs seeding and refinement.
// ----------------------------------------------------------------------------
module tdk_engine
  import tdk_pkg::*;
#(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16
)(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire in_t  cmd,
  input  wire cfg_t cfg,
  output logic      busy,
  output logic      result_valid,
  output out_t      result
);

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int CW   = $clog2(MAX_CLUSTERS);
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int CNTW = $clog2(MAX_POINTS + 2);
  localparam int ACCW = COORD_W + NW + 1;
  localparam int DW   = 2*COORD_W + 2;

  // Memories.
  logic [2*COORD_W-1:0] pt_mem  [MAX_POINTS];
  logic [CW-1:0]        lbl_mem [MAX_POINTS];
  logic [DW-1:0]        nd_mem  [MAX_POINTS];
  logic [ACCW-1:0]      cx_mem  [MAX_CLUSTERS];
  logic [ACCW-1:0]      cy_mem  [MAX_CLUSTERS];
  logic [CNTW-1:0]      cnt_mem [MAX_CLUSTERS];

  logic                 pt_we, pt_re, lbl_we, lbl_re, nd_we, nd_re;
  logic                 cen_we, cnt_we, cen_re;
  logic [PW-1:0]        pt_wa, pt_ra, lbl_ra, z_next_addr;
  logic [2*COORD_W-1:0] pt_wd, pt_q;
  logic [CW-1:0]        lbl_q, cen_wa, cen_ra, lbl_wd;
  logic [DW-1:0]        nd_wd, nd_q;
  logic [ACCW-1:0]      cx_wd, cy_wd, cx_q, cy_q;
  logic [CNTW-1:0]      cnt_wd, cnt_q;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    if (pt_re) pt_q <= pt_mem[pt_ra];
    if (lbl_we) lbl_mem[z_next_addr] <= lbl_wd;
    if (lbl_re) lbl_q <= lbl_mem[lbl_ra];
    if (nd_we) nd_mem[z_next_addr] <= nd_wd;
    if (nd_re) nd_q <= nd_mem[z_next_addr];
    if (cen_we) begin
      cx_mem[cen_wa] <= cx_wd;
      cy_mem[cen_wa] <= cy_wd;
    end
    if (cnt_we) cnt_mem[cen_wa] <= cnt_wd;
    if (cen_re) begin
      cx_q  <= cx_mem[cen_ra];
      cy_q  <= cy_mem[cen_ra];
      cnt_q <= cnt_mem[cen_ra];
    end
  end

  // Sequencer registers.
  state_t                    state, state_next;
  logic [PW-1:0]             z, far;
  logic [CW-1:0]             c, best;
  logic [DW-1:0]             far_d, best_d;
  logic                      moved, iter_mode, run_ovf, rd_ok;
  logic [ITER_W-1:0]         it, limit, run_iter;
  logic [NW-1:0]             n_pts, loaded, labeled;
  logic [KW-1:0]             k_run;
  logic                      ovf;
  logic signed [COORD_W-1:0] cx_r, cy_r, px, py;
  logic [ACCW-1:0]           qx;

  // Units.
  logic                      d_start, d_valid;
  logic [DW-1:0]             d_val;
  logic signed [COORD_W-1:0] d_cx, d_cy;
  logic                      v_start, v_done;
  logic signed [ACCW-1:0]    v_dividend, v_quot;

  assign px = $signed(pt_q[2*COORD_W-1:COORD_W]);
  assign py = $signed(pt_q[COORD_W-1:0]);
  assign d_cx = (state == S_SD_DST) ? cx_r : $signed(cx_q[COORD_W-1:0]);
  assign d_cy = (state == S_SD_DST) ? cy_r : $signed(cy_q[COORD_W-1:0]);
  assign v_dividend = $signed((state == S_DV_X) ? cx_q : cy_q);

  tdk_dist u_dist (
    .clk(clk), .rst(rst), .start(d_start),
    .px(px), .py(py), .cx(d_cx), .cy(d_cy),
    .valid(d_valid), .dsq(d_val)
  );

  tdk_div #(.ACCW(ACCW), .DVW(CNTW)) u_div (
    .clk(clk), .rst(rst), .start(v_start),
    .dividend(v_dividend), .divisor(CNTW'(cnt_q + CNTW'(1))),
    .done(v_done), .quotient(v_quot)
  );

  // Load and run checks.
  logic          room, k_bad, z_last, c_last, nd_take, best_take, moved_now;
  logic [NW-1:0] n_new;

  assign room   = loaded < NW'(MAX_POINTS);
  assign n_new  = room ? NW'(loaded + NW'(1)) : loaded;
  assign k_bad  = (cfg.cluster_count == '0) ||
                  (32'(cfg.cluster_count) > 32'(n_new)) ||
                  (32'(cfg.cluster_count) > MAX_CLUSTERS);
  assign z_last = NW'(z) == NW'(n_pts - NW'(1));
  assign c_last = KW'(c) == KW'(k_run - KW'(1));
  assign nd_take   = (c == '0) || (d_val < nd_q);
  assign best_take = (c == '0) || (d_val < best_d);
  assign moved_now = moved || (best != lbl_q);
  assign z_next_addr = z;

  always_comb begin
    state_next = state;
    pt_we  = 1'b0;
    pt_re  = 1'b0;
    pt_wa  = loaded[PW-1:0];
    pt_wd  = {cmd.x_coord, cmd.y_coord};
    pt_ra  = z;
    lbl_re = 1'b0;
    lbl_ra = z;
    lbl_we = 1'b0;
    lbl_wd = best;
    nd_re  = 1'b0;
    nd_we  = 1'b0;
    nd_wd  = nd_take ? d_val : nd_q;
    cen_re = 1'b0;
    cen_ra = c;
    cen_we = 1'b0;
    cnt_we = 1'b0;
    cen_wa = c;
    cx_wd  = {{(ACCW-COORD_W){px[COORD_W-1]}}, px};
    cy_wd  = {{(ACCW-COORD_W){py[COORD_W-1]}}, py};
    cnt_wd = '0;
    d_start = 1'b0;
    v_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.op == OP_READ) begin
            lbl_re = 1'b1;
            lbl_ra = PW'(cmd.index);
            state_next = S_RD_WAIT;
          end else begin
            pt_we = room;
            if (cmd.last && !k_bad && cfg.max_iterations != '0) begin
              state_next = S_SD_RD0;
            end
          end
        end
      end
      S_RD_WAIT: state_next = S_IDLE;
      S_SD_RD0: begin
        pt_re = 1'b1;
        pt_ra = '0;
        state_next = S_SD_WR0;
      end
      S_SD_WR0: begin
        cen_we = 1'b1;
        state_next = S_SD_RD;
      end
      S_SD_RD: begin
        pt_re = 1'b1;
        nd_re = 1'b1;
        state_next = S_SD_DST;
      end
      S_SD_DST: begin
        d_start = 1'b1;
        state_next = S_SD_WT;
      end
      S_SD_WT: begin
        if (d_valid) begin
          nd_we = 1'b1;
          if (!z_last) state_next = S_SD_RD;
          else if (c_last) state_next = S_AS_RD;
          else state_next = S_SD_FRD;
        end
      end
      S_SD_FRD: begin
        pt_re = 1'b1;
        pt_ra = far;
        state_next = S_SD_FWR;
      end
      S_SD_FWR: begin
        cen_we = 1'b1;
        cen_wa = CW'(c + CW'(1));
        state_next = S_SD_RD;
      end
      S_AS_RD: begin
        pt_re = 1'b1;
        lbl_re = 1'b1;
        state_next = S_AS_CRD;
      end
      S_AS_CRD: begin
        cen_re = 1'b1;
        state_next = S_AS_DST;
      end
      S_AS_DST: begin
        d_start = 1'b1;
        state_next = S_AS_WT;
      end
      S_AS_WT: begin
        if (d_valid) state_next = c_last ? S_AS_WR : S_AS_CRD;
      end
      S_AS_WR: begin
        lbl_we = 1'b1;
        if (!z_last) state_next = S_AS_RD;
        else if (!iter_mode) state_next = S_CL;
        else if (!moved_now || 9'(it) + 9'd1 == 9'(limit)) state_next = S_DONE;
        else state_next = S_CL;
      end
      S_CL: begin
        cnt_we = 1'b1;
        if (c_last) state_next = S_AC_RD;
      end
      S_AC_RD: begin
        pt_re = 1'b1;
        lbl_re = 1'b1;
        state_next = S_AC_CRD;
      end
      S_AC_CRD: begin
        cen_re = 1'b1;
        cen_ra = lbl_q;
        state_next = S_AC_WR;
      end
      S_AC_WR: begin
        cen_we = 1'b1;
        cnt_we = 1'b1;
        cen_wa = lbl_q;
        cx_wd  = cx_q + {{(ACCW-COORD_W){px[COORD_W-1]}}, px};
        cy_wd  = cy_q + {{(ACCW-COORD_W){py[COORD_W-1]}}, py};
        cnt_wd = CNTW'(cnt_q + CNTW'(1));
        state_next = z_last ? S_DV_RD : S_AC_RD;
      end
      S_DV_RD: begin
        cen_re = 1'b1;
        state_next = S_DV_X;
      end
      S_DV_X: begin
        v_start = 1'b1;
        state_next = S_DV_XW;
      end
      S_DV_XW: begin
        if (v_done) state_next = S_DV_Y;
      end
      S_DV_Y: begin
        v_start = 1'b1;
        state_next = S_DV_YW;
      end
      S_DV_YW: begin
        if (v_done) begin
          cen_we = 1'b1;
          cx_wd  = qx;
          cy_wd  = v_quot;
          state_next = c_last ? S_AS_RD : S_DV_RD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Control state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded       <= '0;
      ovf          <= 1'b0;
      labeled      <= '0;
      run_iter     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_RD_WAIT) || (state == S_DONE) ||
                      (state == S_IDLE && start && cmd.op == OP_LOAD && cmd.last &&
                       (k_bad || cfg.max_iterations == '0));
      case (state)
        S_IDLE: begin
          if (start && cmd.op == OP_LOAD) begin
            if (cmd.last) begin
              loaded <= '0;
              ovf    <= 1'b0;
              if (k_bad || cfg.max_iterations == '0) begin
                run_iter <= '0;
                labeled  <= '0;
              end
            end else if (room) begin
              loaded <= NW'(loaded + NW'(1));
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_DONE: begin
          run_iter <= it;
          labeled  <= n_pts;
        end
        default: ;
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        result.kind            <= KIND_RUN;
        result.label           <= '0;
        result.iterations_done <= '0;
        result.status          <= k_bad ? ST_BAD_K : ST_BAD_ITER;
      end
      S_RD_WAIT: begin
        result.kind            <= KIND_READ;
        result.label           <= rd_ok ? LABEL_W'(lbl_q) : '0;
        result.iterations_done <= run_iter;
        result.status          <= rd_ok ? ST_OK : ST_RANGE;
      end
      S_DONE: begin
        result.kind            <= KIND_RUN;
        result.label           <= '0;
        result.iterations_done <= it;
        result.status          <= run_ovf ? ST_OVERFLOW : ST_OK;
      end
      default: ;
    endcase
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rd_ok   <= 32'(cmd.index) < 32'(labeled);
        n_pts   <= n_new;
        k_run   <= KW'(cfg.cluster_count);
        limit   <= cfg.max_iterations;
        run_ovf <= ovf || !room;
        it      <= '0;
        c       <= '0;
        z       <= '0;
      end
      S_SD_WR0: begin
        cx_r <= px;
        cy_r <= py;
      end
      S_SD_WT: begin
        if (d_valid) begin
          if (z == '0 || nd_wd > far_d) begin
            far_d <= nd_wd;
            far   <= z;
          end
          if (!z_last) begin
            z <= PW'(z + PW'(1));
          end else begin
            z         <= '0;
            iter_mode <= 1'b0;
            moved     <= 1'b0;
          end
        end
      end
      S_SD_FWR: begin
        cx_r <= px;
        cy_r <= py;
        c    <= CW'(c + CW'(1));
      end
      S_AS_RD: c <= '0;
      S_AS_WT: begin
        if (d_valid) begin
          if (best_take) begin
            best   <= c;
            best_d <= d_val;
          end
          if (!c_last) c <= CW'(c + CW'(1));
        end
      end
      S_AS_WR: begin
        moved <= iter_mode && moved_now;
        c     <= '0;
        if (!z_last) begin
          z <= PW'(z + PW'(1));
        end else begin
          z <= '0;
          if (iter_mode && moved_now) it <= ITER_W'(it + ITER_W'(1));
        end
      end
      S_CL: begin
        if (!c_last) c <= CW'(c + CW'(1));
      end
      S_AC_WR: begin
        if (!z_last) begin
          z <= PW'(z + PW'(1));
        end else begin
          z <= '0;
          c <= '0;
        end
      end
      S_DV_XW: begin
        if (v_done) qx <= v_quot;
      end
      S_DV_YW: begin
        if (v_done) begin
          if (c_last) begin
            iter_mode <= 1'b1;
            moved     <= 1'b0;
            z         <= '0;
          end else begin
            c <= CW'(c + CW'(1));
          end
        end
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

endmodule : tdk_engine
`default_nettype wire

// ----- hw/rtl/two_d_kmeans_clusterer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_d_kmeans_clusterer
// K-means clustering of two-dimensional Q8.8 points with farthest-first
// seeding, built around point, label and centroid memories.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. A load
// command writes one point per cycle into the point memory. A load marked
// last closes the set and starts a clustering run, during which busy stays
// high; an invalid k or iteration limit gives an error result instead. A
// read command returns the label of one point, read from the label memory
// and then registered onto result. Every result appears on result for
// exactly one cycle, marked by result_valid; the receiver cannot stall, so it
// must take each result then. Loads without last give no result. A run seeds
// the centroids, then alternates assignment passes with centroid updates that
// clear the counts, accumulate the points and do two serial divisions per
// cluster. The two registers are written through the cfg channel, whose ready
// is always high; writes are made only while the block is idle, which the
// user must keep to and the block does not enforce. Reset clears the
// registers to k = 2 and a limit of 10 iterations, empties the point set and
// leaves no labels readable; the memories themselves are not cleared.
// ----------------------------------------------------------------------------
module two_d_kmeans_clusterer
  import tdk_pkg::*;
#(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_t                   cmd,
  output logic                       result_valid,
  output out_t                       result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // Always accepted; the user keeps the block idle whenever it is written.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cluster_count  <= KCFG_W'(2);
      cfg.max_iterations <= ITER_W'(10);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLUSTER_COUNT:  cfg.cluster_count  <= cfg_data[KCFG_W-1:0];
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // The engine holds every memory and the run sequencer.
  tdk_engine #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .cfg(cfg),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

endmodule : two_d_kmeans_clusterer
`default_nettype wire
